// ----- rtl/qte_pkg.sv -----
// Shared types, constants and arithmetic helpers for the quaternion to Euler block.
// No dependencies; every RTL file imports this package.
`timescale 1ns / 1ps

package qte_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TAB_LEN       = 24;

    // Widths of the fixed-point terms
    localparam int SW = 34;   // numerators, 2 * (sum of two products)
    localparam int DW = 33;   // denominators, sum of four squares
    localparam int VW = 37;   // CORDIC vector, covers gain and pre-rotation
    localparam int AW = 31;   // angle accumulator, 2^-20 degree
    localparam int RW = 61;   // square root radicand, up to 2^60
    localparam int QW = 31;   // square root result, one bit per stage
    localparam int OW = 16;   // rounded angle before narrowing

    localparam logic signed [AW-1:0] DEG90  = AW'(94371840);
    localparam logic signed [AW-1:0] DEG180 = AW'(188743680);
    localparam int LIM_X  = 11520;
    localparam int LIM_YZ = 23040;
    localparam logic signed [SW-1:0] ONE30 = SW'(64'sd1073741824);

    typedef struct packed {
        logic signed [SW-1:0] s;
        logic                 clamp_pos;
        logic                 clamp_neg;
        logic signed [SW-1:0] yn;
        logic signed [DW-1:0] yd;
        logic signed [SW-1:0] zn;
        logic signed [DW-1:0] zd;
    } front_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QW-1:0] root;
        front_t        f;
    } sqrt_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] acc;
        logic                 byp;
    } lane_t;

    typedef struct packed {
        lane_t ax;
        lane_t ay;
        lane_t az;
        logic  clamp_pos;
        logic  clamp_neg;
    } cordic_t;

    // atan(2^-i) in degrees, scaled by 2^20
    function automatic logic signed [AW-1:0] atan_tab(input int i);
        logic signed [AW-1:0] v;
        case (i)
            0:  v = AW'(47185920);
            1:  v = AW'(27855475);
            2:  v = AW'(14718068);
            3:  v = AW'(7471121);
            4:  v = AW'(3750058);
            5:  v = AW'(1876857);
            6:  v = AW'(938658);
            7:  v = AW'(469357);
            8:  v = AW'(234682);
            9:  v = AW'(117342);
            10: v = AW'(58671);
            11: v = AW'(29335);
            12: v = AW'(14668);
            13: v = AW'(7334);
            14: v = AW'(3667);
            15: v = AW'(1833);
            16: v = AW'(917);
            17: v = AW'(458);
            18: v = AW'(229);
            19: v = AW'(115);
            20: v = AW'(57);
            21: v = AW'(29);
            22: v = AW'(14);
            23: v = AW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Set up one arctangent: settle the axis cases, turn the left half plane right
    function automatic lane_t lane_init(input logic signed [VW-1:0] yi,
                                        input logic signed [VW-1:0] xi);
        lane_t l;
        l.x   = xi;
        l.y   = yi;
        l.acc = '0;
        l.byp = 1'b0;
        if (yi == '0) begin
            l.byp = 1'b1;
            l.acc = (xi < 0) ? DEG180 : '0;
        end else if (xi == '0) begin
            l.byp = 1'b1;
            l.acc = (yi > 0) ? DEG90 : -DEG90;
        end else if (xi < 0) begin
            if (yi > 0) begin
                l.x   = yi;
                l.y   = -xi;
                l.acc = DEG90;
            end else begin
                l.x   = -yi;
                l.y   = xi;
                l.acc = -DEG90;
            end
        end
        return l;
    endfunction

    // One vectoring micro-rotation
    function automatic lane_t lane_step(input lane_t l, input int i);
        lane_t                r;
        logic signed [VW-1:0] lx;
        logic signed [VW-1:0] ly;
        logic signed [VW-1:0] dx;
        logic signed [VW-1:0] dy;
        r  = l;
        lx = l.x;
        ly = l.y;
        dx = ly >>> i;
        dy = lx >>> i;
        if (!l.byp) begin
            if (ly > 0) begin
                r.x   = lx + dx;
                r.y   = ly - dy;
                r.acc = l.acc + atan_tab(i);
            end else begin
                r.x   = lx - dx;
                r.y   = ly + dy;
                r.acc = l.acc - atan_tab(i);
            end
        end
        return r;
    endfunction

    // Round to 1/128 degree, half up, and saturate
    function automatic logic signed [OW-1:0] to_out(input logic signed [AW-1:0] a,
                                                    input int lim);
        logic signed [AW:0] t;
        logic signed [AW:0] r;
        t = (AW+1)'(a) + (AW+1)'(4096);
        r = t >>> 13;
        if (r > (AW+1)'(lim))
            r = (AW+1)'(lim);
        if (r < -(AW+1)'(lim))
            r = -(AW+1)'(lim);
        return OW'(r);
    endfunction

endpackage

// ----- rtl/qte_front.sv -----
// Front end: takes quaternion beats, forms all products and the three
// numerator/denominator pairs, and pushes them into the queue. Uses qte_pkg.
`timescale 1ns / 1ps

module qte_front
    import qte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    input  fifo_stat_t         q_stat,
    output logic               push,
    output front_t             push_data
);

    logic               valid_reg;
    logic               valid_next;
    logic signed [31:0] p_xx_reg, p_yy_reg, p_zz_reg, p_ww_reg;
    logic signed [31:0] p_wx_reg, p_yz_reg, p_xz_reg, p_wy_reg, p_xy_reg, p_zw_reg;
    logic               take;
    logic signed [DW-1:0] d_s, d_y, d_z;

    // Hold the products while the queue is full
    assign push     = valid_reg && !q_stat.full;
    assign in_stall = valid_reg && q_stat.full;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
            valid_next = 1'b0;
        if (take)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Register one product per multiplier
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            p_xx_reg <= quat_x * quat_x;
            p_yy_reg <= quat_y * quat_y;
            p_zz_reg <= quat_z * quat_z;
            p_ww_reg <= quat_w * quat_w;
            p_wx_reg <= quat_w * quat_x;
            p_yz_reg <= quat_y * quat_z;
            p_xz_reg <= quat_x * quat_z;
            p_wy_reg <= quat_w * quat_y;
            p_xy_reg <= quat_x * quat_y;
            p_zw_reg <= quat_z * quat_w;
        end
    end

    // Combine products into numerators and denominators
    always_comb
    begin
        d_s = DW'(p_wx_reg) - DW'(p_yz_reg);
        d_y = DW'(p_xz_reg) + DW'(p_wy_reg);
        d_z = DW'(p_xy_reg) + DW'(p_zw_reg);
        push_data.s  = {d_s, 1'b0};
        push_data.yn = {d_y, 1'b0};
        push_data.zn = {d_z, 1'b0};
        push_data.yd = -DW'(p_xx_reg) - DW'(p_yy_reg) + DW'(p_zz_reg) + DW'(p_ww_reg);
        push_data.zd = -DW'(p_xx_reg) + DW'(p_yy_reg) - DW'(p_zz_reg) + DW'(p_ww_reg);
        push_data.clamp_pos = (push_data.s >= ONE30);
        push_data.clamp_neg = (push_data.s <= -ONE30);
    end

endmodule

// ----- rtl/qte_fifo.sv -----
// Four-entry queue between the front end and the CORDIC back end.
// Uses qte_pkg for the entry type and status struct.
`timescale 1ns / 1ps

module qte_fifo
    import qte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  front_t     push_data,
    input  logic       pop,
    output front_t     pop_data,
    output fifo_stat_t stat
);

    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    front_t     mem_reg [0:3];

    assign stat.full  = (cnt_reg == 3'd4);
    assign stat.empty = (cnt_reg == 3'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + 2'(push);
        rd_ptr_next = rd_ptr_reg + 2'(pop);
        cnt_next    = cnt_reg + 3'(push) - 3'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- rtl/qte_back.sv -----
// Back end: square, bit-per-stage square root, three CORDIC lanes and
// rounding, all advancing together under output stall. Uses qte_pkg.
`timescale 1ns / 1ps

module qte_back
    import qte_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fifo_stat_t           q_stat,
    input  front_t               q_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [14:0]   angle_x,
    output logic signed [15:0]   angle_y,
    output logic signed [15:0]   angle_z,
    output logic                 gimbal_clamped
);

    logic    adv;
    logic    sr_v_reg [0:QW];
    sqrt_t   sr_reg   [0:QW];
    sqrt_t   sr_next  [0:QW];
    logic    cr_v_reg [0:CORDIC_STAGES];
    cordic_t cr_reg   [0:CORDIC_STAGES];
    cordic_t cr_next  [0:CORDIC_STAGES];
    logic    out_valid_reg;
    logic signed [14:0] angle_x_reg, angle_x_next;
    logic signed [15:0] angle_y_reg, angle_y_next;
    logic signed [15:0] angle_z_reg, angle_z_next;
    logic    clamp_reg, clamp_next;
    logic signed [SW-1:0] s_mag;
    logic [2*(QW-1)-1:0]  s_sq;
    logic signed [OW-1:0] ax_round;

    // Whole back end moves when the output register is free
    assign adv            = !out_valid_reg || !out_stall;
    assign pop            = adv && !q_stat.empty;
    assign out_valid      = out_valid_reg;
    assign angle_x        = angle_x_reg;
    assign angle_y        = angle_y_reg;
    assign angle_z        = angle_z_reg;
    assign gimbal_clamped = clamp_reg;

    // Form the radicand 1 - s^2 at 2^-60 scale
    always_comb
    begin
        s_mag = (q_data.s < 0) ? -q_data.s : q_data.s;
        s_sq  = (q_data.clamp_pos || q_data.clamp_neg) ? '0 :
                s_mag[QW-2:0] * s_mag[QW-2:0];
        sr_next[0].f    = q_data;
        sr_next[0].root = '0;
        sr_next[0].rem  = {1'b1, {(RW-1){1'b0}}} - {1'b0, s_sq};
    end

    // Square root, one result bit per stage
    for (genvar j = 0; j < QW; j++)
    begin : g_sqrt
        localparam int K = QW - 1 - j;
        logic [RW+1:0] trial;
        always_comb
        begin
            trial = ((RW+2)'(sr_reg[j].root) << (K + 1)) + ((RW+2)'(1) << (2 * K));
            sr_next[j+1] = sr_reg[j];
            if ((RW+2)'(sr_reg[j].rem) >= trial)
            begin
                sr_next[j+1].rem  = sr_reg[j].rem - RW'(trial);
                sr_next[j+1].root = sr_reg[j].root | (QW'(1) << K);
            end
        end
    end

    // Set up the three arctangents
    always_comb
    begin
        cr_next[0].ax = lane_init(VW'(sr_reg[QW].f.s), VW'({1'b0, sr_reg[QW].root}));
        cr_next[0].ay = lane_init(VW'(sr_reg[QW].f.yn), VW'(sr_reg[QW].f.yd));
        cr_next[0].az = lane_init(VW'(sr_reg[QW].f.zn), VW'(sr_reg[QW].f.zd));
        cr_next[0].clamp_pos = sr_reg[QW].f.clamp_pos;
        cr_next[0].clamp_neg = sr_reg[QW].f.clamp_neg;
    end

    // CORDIC micro-rotations
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        always_comb
        begin
            cr_next[i+1]    = cr_reg[i];
            cr_next[i+1].ax = lane_step(cr_reg[i].ax, i);
            cr_next[i+1].ay = lane_step(cr_reg[i].ay, i);
            cr_next[i+1].az = lane_step(cr_reg[i].az, i);
        end
    end

    // Round, saturate and apply the gimbal clamp
    always_comb
    begin
        ax_round     = to_out(cr_reg[CORDIC_STAGES].ax.acc, LIM_X);
        angle_x_next = ax_round[14:0];
        if (cr_reg[CORDIC_STAGES].clamp_pos)
            angle_x_next = 15'(LIM_X);
        else if (cr_reg[CORDIC_STAGES].clamp_neg)
            angle_x_next = -15'(LIM_X);
        angle_y_next = to_out(cr_reg[CORDIC_STAGES].ay.acc, LIM_YZ);
        angle_z_next = to_out(cr_reg[CORDIC_STAGES].az.acc, LIM_YZ);
        clamp_next   = cr_reg[CORDIC_STAGES].clamp_pos || cr_reg[CORDIC_STAGES].clamp_neg;
    end

    // Valid bits follow the data down the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n <= QW; n++)
                sr_v_reg[n] <= 1'b0;
            for (int n = 0; n <= CORDIC_STAGES; n++)
                cr_v_reg[n] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sr_v_reg[0] <= !q_stat.empty;
            for (int n = 1; n <= QW; n++)
                sr_v_reg[n] <= sr_v_reg[n-1];
            cr_v_reg[0] <= sr_v_reg[QW];
            for (int n = 1; n <= CORDIC_STAGES; n++)
                cr_v_reg[n] <= cr_v_reg[n-1];
            out_valid_reg <= cr_v_reg[CORDIC_STAGES];
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int n = 0; n <= QW; n++)
                sr_reg[n] <= sr_next[n];
            for (int n = 0; n <= CORDIC_STAGES; n++)
                cr_reg[n] <= cr_next[n];
            angle_x_reg <= angle_x_next;
            angle_y_reg <= angle_y_next;
            angle_z_reg <= angle_z_next;
            clamp_reg   <= clamp_next;
        end
    end

endmodule

// ----- rtl/quaternion_to_euler_degrees.sv -----
// Top level: quaternion (Q1.15) to Y-X-Z Euler angles in 1/128 degree.
// Instantiates qte_front, qte_fifo and qte_back; uses qte_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   input   | in_valid / in_stall  | quat_x, quat_y, quat_z, quat_w
//   output  | out_valid / out_stall| angle_x, angle_y, angle_z, gimbal_clamped
//
// Throughput is one beat per cycle while in_stall stays low. The path runs
// through the product register, queue, square, 31 square-root stages, CORDIC
// setup, CORDIC stages and output register; the square root is its longest part.
// Reset clears only valid bits, queue pointers and queue count; no clearing pass.
// An output stall on a valid result freezes the back end; the four-entry queue then fills
// before in_stall rises.
`timescale 1ns / 1ps

module quaternion_to_euler_degrees
    import qte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] angle_x,
    output logic signed [15:0] angle_y,
    output logic signed [15:0] angle_z,
    output logic               gimbal_clamped
);

    fifo_stat_t q_stat;
    front_t     push_data;
    front_t     pop_data;
    logic       push;
    logic       pop;

    qte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    qte_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    qte_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .q_data         (pop_data),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .angle_x        (angle_x),
        .angle_y        (angle_y),
        .angle_z        (angle_z),
        .gimbal_clamped (gimbal_clamped)
    );

    // A clamped beat carries exactly plus or minus ninety degrees
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gimbal_clamped |-> (angle_x == 15'sd11520 || angle_x == -15'sd11520))
        else $error("clamped angle_x is not +-90 degrees");

    // Saturation keeps the atan2 angles inside one half turn
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (angle_y <= 16'sd23040 && angle_y >= -16'sd23040 &&
                       angle_z <= 16'sd23040 && angle_z >= -16'sd23040))
        else $error("angle_y or angle_z out of range");

    // Never pop an empty queue nor push a full one
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_stat.empty) && !(push && q_stat.full))
        else $error("queue overrun or underrun");

endmodule

// ----- verif/testbench.sv -----
// Testbench for quaternion_to_euler_degrees: random and directed quaternions,
// scoreboard with its own fixed-point CORDIC predictor. Depends on the RTL only.
`timescale 1ns / 1ps

class euler_scoreboard;
    typedef struct {
        logic signed [14:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic               clamp;
    } angles_t;

    angles_t pending[$];
    int      errors;

    static function longint asr(longint v, int s);
        return v >>> s;
    endfunction

    static function longint atan_deg(int i);
        longint tab[24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
                            938658, 469357, 234682, 117342, 58671, 29335, 14668,
                            7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
        return tab[i];
    endfunction

    // exact floor square root
    static function longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // vectoring CORDIC, angle in 2^-20 degree
    static function longint vector_angle(longint y, longint x);
        longint acc;
        longint t;
        longint nx;
        longint ny;
        acc = 0;
        if (y == 0) return (x < 0) ? 188743680 : 0;
        if (x == 0) return (y > 0) ? 94371840 : -94371840;
        if (x < 0)
        begin
            if (y > 0)
            begin
                t = x; x = y; y = -t; acc = 94371840;
            end
            else
            begin
                t = x; x = -y; y = t; acc = -94371840;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            if (y > 0)
            begin
                nx = x + asr(y, i); ny = y - asr(x, i); acc += atan_deg(i);
            end
            else
            begin
                nx = x - asr(y, i); ny = y + asr(x, i); acc -= atan_deg(i);
            end
            x = nx;
            y = ny;
        end
        return acc;
    endfunction

    static function longint round_deg(longint a, longint lim);
        longint r;
        r = (a + 4096) >>> 13;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    // note an accepted quaternion
    function void note_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                            logic signed [15:0] qz, logic signed [15:0] qw);
        longint  x;
        longint  y;
        longint  z;
        longint  w;
        longint  s;
        longint  c;
        angles_t e;
        x = qx; y = qy; z = qz; w = qw;
        s = 2 * (w * x - y * z);
        e.clamp = 1'b0;
        if (s >= 64'sd1073741824)
        begin
            e.ax = 15'sd11520; e.clamp = 1'b1;
        end
        else if (s <= -64'sd1073741824)
        begin
            e.ax = -15'sd11520; e.clamp = 1'b1;
        end
        else
        begin
            c = int_sqrt(64'd1152921504606846976 - longint'(s * s));
            e.ax = 15'(round_deg(vector_angle(s, c), 11520));
        end
        e.ay = 16'(round_deg(vector_angle(2 * (x * z + w * y),
                                          -x*x - y*y + z*z + w*w), 23040));
        e.az = 16'(round_deg(vector_angle(2 * (x * y + z * w),
                                          -x*x + y*y - z*z + w*w), 23040));
        pending.insert(pending.size(), e);
    endfunction

    function void report(string what);
        $display("mismatch: %s", what);
        errors++;
    endfunction

    // check one result beat against the oldest expectation
    function void check_angles(logic signed [14:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az, logic clamp);
        angles_t e;
        if (pending.size() == 0)
        begin
            report("unexpected result beat");
            return;
        end
        e = pending.pop_front();
        if (ax !== e.ax) report($sformatf("angle_x %0d exp %0d", ax, e.ax));
        if (ay !== e.ay) report($sformatf("angle_y %0d exp %0d", ay, e.ay));
        if (az !== e.az) report($sformatf("angle_z %0d exp %0d", az, e.az));
        if (clamp !== e.clamp) report($sformatf("gimbal_clamped %0b exp %0b", clamp, e.clamp));
    endfunction
endclass

module testbench;
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] quat_x = '0;
    logic signed [15:0] quat_y = '0;
    logic signed [15:0] quat_z = '0;
    logic signed [15:0] quat_w = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [14:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic               gimbal_clamped;
    logic               sending_done = 1'b0;

    euler_scoreboard board = new();

    quaternion_to_euler_degrees dut (.*);

    always #5 clk = ~clk;

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 5) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    // send one beat, hold until accepted, then maybe idle
    task automatic send_quat(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic signed [15:0] w, int gap);
        quat_x <= x; quat_y <= y; quat_z <= z; quat_w <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        board.note_quat(x, y, z, w);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // random component: full range, near extremes, or a small 14-bit value
    function automatic logic signed [15:0] rand_comp(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7FFF - 16'($urandom_range(0, 3))
                                           : 16'sh8000 + 16'($urandom_range(0, 3));
            default: return 16'($signed(14'($urandom)));
        endcase
    endfunction

    // check result beats at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_angles(angle_x, angle_y, angle_z, gimbal_clamped);
    end

    // randomize output stall at the falling edge; some stretches stay open
    initial
    begin
        int hold;
        @(posedge rst_n);
        while (!sending_done)
        begin
            @(negedge clk);
            if ($urandom_range(0, 3) == 0)
            begin
                hold = gap_len();
                if (hold > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
            else
                repeat ($urandom_range(0, 40)) @(negedge clk);
        end
    end

    initial
    begin
        int m;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: axes, extremes, gimbal cases, atan2 zero cases
        send_quat(0, 0, 0, 0, 0);
        send_quat(0, 0, 0, 16'sh7FFF, 0);
        send_quat(0, 0, 0, 16'sh8000, 1);
        send_quat(16'sh7FFF, 0, 0, 0, 0);
        send_quat(0, 16'sh7FFF, 0, 0, 0);
        send_quat(0, 0, 16'sh7FFF, 0, 0);
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
        send_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 2);
        send_quat(23170, 0, 0, 23170, 0);
        send_quat(-23170, 0, 0, 23170, 0);
        send_quat(0, 23170, 23170, 0, 0);
        send_quat(16384, 16384, 16384, 16384, 0);
        send_quat(16384, -16384, 16384, 16384, 0);
        send_quat(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 0);
        send_quat(0, 16'sh8000, 0, 16'sh7FFF, 0);
        send_quat(0, 0, 16'sh8000, 16'sh7FFF, 0);
        send_quat(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 0);
        send_quat(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 0);
        send_quat(1, 0, 0, 0, 0);
        send_quat(0, 0, 1, 16'sh8000, 0);
        // random part
        for (int i = 0; i < 850; i++)
        begin
            m = $urandom_range(0, 9);
            m = (m < 5) ? 0 : (m < 7) ? 1 : 2;
            send_quat(rand_comp(m), rand_comp(m), rand_comp(m), rand_comp(m), gap_len());
        end
        in_valid <= 1'b0;
        sending_done <= 1'b1;
        wait (board.pending.size() == 0);
        repeat (80) @(posedge clk);
        if (board.errors == 0)
            $display("quaternion_to_euler_degrees test passed");
        else
            $display("quaternion_to_euler_degrees test failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("quaternion_to_euler_degrees test failed");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/qte_pkg.sv
rtl/qte_front.sv
rtl/qte_fifo.sv
rtl/qte_back.sv
rtl/quaternion_to_euler_degrees.sv
verif/testbench.sv
